### src/fixed_point_q24_8_alu_unit_defines.svh
// Assertion helpers shared by the RTL files of the fixed-point ALU.
`ifndef FIXED_POINT_Q24_8_ALU_UNIT_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property checked at every rising clock edge outside reset.
`define FXA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FXA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`else

`define FXA_ASSERT(lbl, prop, msg)
`define FXA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### src/fxalu_pkg.sv
package fxalu_pkg;

   typedef enum logic [3:0] {
      FUNC_ADD      = 4'd0,
      FUNC_SUB      = 4'd1,
      FUNC_MUL      = 4'd2,
      FUNC_DIV      = 4'd3,
      FUNC_LT       = 4'd4,
      FUNC_LE       = 4'd5,
      FUNC_GT       = 4'd6,
      FUNC_GE       = 4'd7,
      FUNC_EQ       = 4'd8,
      FUNC_NE       = 4'd9,
      FUNC_INC      = 4'd10,
      FUNC_DEC      = 4'd11,
      FUNC_MIN      = 4'd12,
      FUNC_MAX      = 4'd13,
      FUNC_TO_INT   = 4'd14,
      FUNC_FROM_INT = 4'd15
   } func_type;

   localparam logic [31:0] SMAX32 = 32'h7FFF_FFFF;
   localparam logic [31:0] SMIN32 = 32'h8000_0000;

   localparam int QUEUE_DEPTH = 4;

   // One classified request as it waits between the front and the back.
   typedef struct packed {
      func_type    func;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] mag_a;
      logic [31:0] mag_b;
      logic        neg;
      logic        dbz;
   } item_type;

   // One finished result.
   typedef struct packed {
      logic [31:0] res;
      logic        cmp;
      logic        ovf;
      logic        dbz;
   } rsp_type;

endpackage

### src/fxalu_front.sv
module fxalu_front (
   input  logic [3:0]         func,
   input  logic [31:0]        a_raw,
   input  logic [31:0]        b_raw,
   output fxalu_pkg::item_type item
);

   // Magnitudes are unsigned, so the most negative value maps to 2^31 exactly.
   always_comb begin
      item.func  = fxalu_pkg::func_type'(func);
      item.a     = a_raw;
      item.b     = b_raw;
      item.mag_a = a_raw[31] ? 32'(32'd0 - a_raw) : a_raw;
      item.mag_b = b_raw[31] ? 32'(32'd0 - b_raw) : b_raw;
      item.neg   = a_raw[31] ^ b_raw[31];
      item.dbz   = (fxalu_pkg::func_type'(func) == fxalu_pkg::FUNC_DIV) && (b_raw == 32'd0);
   end

endmodule

### src/fxalu_queue.sv
`include "fixed_point_q24_8_alu_unit_defines.svh"

module fxalu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fxalu_pkg::item_type push_item,
   input  logic                pop,
   output fxalu_pkg::item_type head,
   output logic                empty,
   output logic                full
);

   localparam int DEPTH = fxalu_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);

   fxalu_pkg::item_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (PW+1)'(DEPTH));
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = (PW+1)'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = (PW+1)'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   `FXA_ASSERT(a_no_pop_when_empty, !(pop && empty), "queue popped while empty")
   `FXA_ASSERT(a_count_matches_ptrs, PW'(wr_ptr_ff - rd_ptr_ff) == cnt_ff[PW-1:0], "queue count and pointers disagree")

endmodule

### src/fxalu_back.sv
`include "fixed_point_q24_8_alu_unit_defines.svh"

module fxalu_back #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  fxalu_pkg::item_type head,
   input  logic                q_empty,
   output logic                pop,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output fxalu_pkg::rsp_type  rsp
);

   // Width of the shifted dividend and of the raw quotient.
   localparam int NW = 32 + FRACTION_BITS;

   typedef struct packed {
      fxalu_pkg::func_type func;
      logic [31:0]         res;
      logic                cmp;
      logic                ovf;
      logic                dbz;
      logic                neg;
      logic [63:0]         prod;
      logic [NW-1:0]       num;
      logic [NW-1:0]       quo;
      logic [31:0]         rem;
      logic [31:0]         den;
   } stage_type;

   // Clamp a sign and magnitude to the signed 32-bit range: {overflow, value}.
   function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] mag);
      logic [32:0] r;
      if (neg) begin
         if (mag > 64'h0000_0000_8000_0000) begin
            r = {1'b1, fxalu_pkg::SMIN32};
         end else begin
            r = {1'b0, 32'(32'd0 - mag[31:0])};
         end
      end else begin
         if (mag > 64'h0000_0000_7FFF_FFFF) begin
            r = {1'b1, fxalu_pkg::SMAX32};
         end else begin
            r = {1'b0, mag[31:0]};
         end
      end
      return r;
   endfunction

   // One restoring division step: one quotient bit.
   function automatic stage_type div_step(input stage_type s);
      stage_type   o;
      logic [32:0] t;
      logic [32:0] d;
      logic        ge;
      o      = s;
      t      = {s.rem, s.num[NW-1]};
      d      = t - {1'b0, s.den};
      ge     = (t >= {1'b0, s.den});
      o.rem  = ge ? d[31:0] : t[31:0];
      o.num  = {s.num[NW-2:0], 1'b0};
      o.quo  = {s.quo[NW-2:0], ge};
      return o;
   endfunction

   stage_type stg_ff [NW+1];
   stage_type stg_in [NW+1];
   logic [NW:0] vld_ff;

   logic                adv;
   logic                rsp_valid_ff;
   fxalu_pkg::rsp_type  rsp_ff, rsp_in;

   // The whole pipe moves unless a finished result sits unread.
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign pop       = adv && !q_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // First stage: short operations finish here, the product is formed
   // and the divider is loaded.
   logic [32:0]            y33;
   logic                   cin;
   logic [32:0]            sum33;
   logic                   add_ovf;
   logic                   lt, gt, eq;
   logic [NW-1:0]          fi_wide;
   logic [FRACTION_BITS:0] fi_hi;
   logic                   fi_ovf;

   always_comb begin
      y33 = {head.b[31], head.b};
      cin = 1'b0;
      case (head.func)
         fxalu_pkg::FUNC_SUB: begin
            y33 = ~{head.b[31], head.b};
            cin = 1'b1;
         end
         fxalu_pkg::FUNC_INC: begin
            y33 = '0;
            cin = 1'b1;
         end
         fxalu_pkg::FUNC_DEC: begin
            y33 = '1;
         end
         default: begin
            y33 = {head.b[31], head.b};
         end
      endcase
      sum33   = 33'({head.a[31], head.a} + y33 + {32'd0, cin});
      add_ovf = sum33[32] ^ sum33[31];
      lt      = $signed(head.a) < $signed(head.b);
      gt      = $signed(head.b) < $signed(head.a);
      eq      = (head.a == head.b);
      fi_wide = {{FRACTION_BITS{head.a[31]}}, head.a} << FRACTION_BITS;
      fi_hi   = fi_wide[NW-1:31];
      fi_ovf  = !((&fi_hi) || !(|fi_hi));
   end

   always_comb begin
      stg_in[0].func = head.func;
      stg_in[0].res  = '0;
      stg_in[0].cmp  = 1'b0;
      stg_in[0].ovf  = 1'b0;
      stg_in[0].dbz  = head.dbz;
      stg_in[0].neg  = head.neg;
      stg_in[0].prod = 64'(head.mag_a) * 64'(head.mag_b);
      stg_in[0].num  = NW'(head.mag_a) << FRACTION_BITS;
      stg_in[0].quo  = '0;
      stg_in[0].rem  = '0;
      stg_in[0].den  = head.mag_b;
      case (head.func)
         fxalu_pkg::FUNC_ADD, fxalu_pkg::FUNC_SUB,
         fxalu_pkg::FUNC_INC, fxalu_pkg::FUNC_DEC: begin
            stg_in[0].ovf = add_ovf;
            if (add_ovf) begin
               stg_in[0].res = sum33[32] ? fxalu_pkg::SMIN32 : fxalu_pkg::SMAX32;
            end else begin
               stg_in[0].res = sum33[31:0];
            end
         end
         fxalu_pkg::FUNC_LT: stg_in[0].cmp = lt;
         fxalu_pkg::FUNC_LE: stg_in[0].cmp = !gt;
         fxalu_pkg::FUNC_GT: stg_in[0].cmp = gt;
         fxalu_pkg::FUNC_GE: stg_in[0].cmp = !lt;
         fxalu_pkg::FUNC_EQ: stg_in[0].cmp = eq;
         fxalu_pkg::FUNC_NE: stg_in[0].cmp = !eq;
         fxalu_pkg::FUNC_MIN: stg_in[0].res = gt ? head.b : head.a;
         fxalu_pkg::FUNC_MAX: stg_in[0].res = lt ? head.b : head.a;
         fxalu_pkg::FUNC_TO_INT: begin
            stg_in[0].res = 32'($signed(head.a) >>> FRACTION_BITS);
         end
         fxalu_pkg::FUNC_FROM_INT: begin
            stg_in[0].ovf = fi_ovf;
            if (fi_ovf) begin
               stg_in[0].res = head.a[31] ? fxalu_pkg::SMIN32 : fxalu_pkg::SMAX32;
            end else begin
               stg_in[0].res = fi_wide[31:0];
            end
         end
         default: begin
            stg_in[0].res = '0;
         end
      endcase
   end

   // Multiply rounding rides along with the first division step.
   logic [63:0] mul_pr;
   logic [63:0] mul_q;
   logic [32:0] mul_out;

   always_comb begin
      mul_pr  = stg_ff[0].prod + (64'd1 << (FRACTION_BITS - 1));
      mul_q   = mul_pr >> FRACTION_BITS;
      mul_out = sat_mag(stg_ff[0].neg, mul_q);
   end

   for (genvar k = 1; k <= NW; k++) begin : g_div
      always_comb begin
         stg_in[k] = div_step(stg_ff[k-1]);
         if ((k == 1) && (stg_ff[0].func == fxalu_pkg::FUNC_MUL)) begin
            stg_in[k].ovf = mul_out[32];
            stg_in[k].res = mul_out[31:0];
         end
      end
   end

   // Last stage: round the quotient to nearest and clamp it.
   logic          div_rnd;
   logic [NW:0]   div_q;
   logic [32:0]   div_out;

   always_comb begin
      div_rnd = ({stg_ff[NW].rem, 1'b0} >= {1'b0, stg_ff[NW].den});
      div_q   = {1'b0, stg_ff[NW].quo} + {{NW{1'b0}}, div_rnd};
      div_out = sat_mag(stg_ff[NW].neg, 64'(div_q));
      rsp_in.res = stg_ff[NW].res;
      rsp_in.cmp = stg_ff[NW].cmp;
      rsp_in.ovf = stg_ff[NW].ovf;
      rsp_in.dbz = stg_ff[NW].dbz;
      if (stg_ff[NW].func == fxalu_pkg::FUNC_DIV) begin
         if (stg_ff[NW].dbz) begin
            rsp_in.res = '0;
            rsp_in.ovf = 1'b0;
         end else begin
            rsp_in.res = div_out[31:0];
            rsp_in.ovf = div_out[32];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[NW-1:0], !q_empty};
         rsp_valid_ff <= vld_ff[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= NW; k++) begin
            stg_ff[k] <= stg_in[k];
         end
         rsp_ff <= rsp_in;
      end
   end

   `FXA_ASSERT(a_cmp_has_zero_result, !(rsp_valid_ff && rsp_ff.cmp && (rsp_ff.res != 32'd0)), "comparison result carries a nonzero value")
   `FXA_ASSERT(a_dbz_gives_zero, !(rsp_valid_ff && rsp_ff.dbz && ((rsp_ff.res != 32'd0) || rsp_ff.ovf)), "divide by zero must return zero without overflow")
   `FXA_ASSERT_NEXT(a_pipe_frozen_on_stall, rsp_valid_ff && rsp_stall, $stable(vld_ff), "pipeline moved while the result was stalled")

endmodule

### src/fixed_point_q24_8_alu_unit.sv
// Signed fixed-point ALU on 32-bit raw values with FRACTION_BITS fraction bits
// (Q24.8 at the default). Each request beat carries an operation code and two
// raw operands and yields exactly one result beat, in request order. Add, sub,
// inc, dec, multiply, divide and from-integer saturate to the signed 32-bit
// range and raise overflow; multiply and divide round to nearest with ties away
// from zero; divide by zero returns zero and raises divide_by_zero; comparisons
// return their outcome on compare_true with a zero result; to-integer is an
// arithmetic shift that rounds toward minus infinity. The unit takes one beat
// per cycle while its queue has room; the queue fills only while the result
// port stalls. Every operation takes the same path through the queue and a
// pipeline whose depth is set by the divider, which forms one quotient bit per
// stage over the 32 + FRACTION_BITS bits of the shifted dividend.
module fixed_point_q24_8_alu_unit #(
   parameter int FRACTION_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_func,
   input  logic signed [31:0] req_a_raw,
   input  logic signed [31:0] req_b_raw,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_raw,
   output logic               rsp_compare_true,
   output logic               rsp_overflow,
   output logic               rsp_divide_by_zero
);

   // The front decodes the operation and forms operand magnitudes and the
   // result sign. Its output goes straight into a short queue, so a stalled
   // result port does not block acceptance until the queue is full.
   fxalu_pkg::item_type push_item;
   fxalu_pkg::item_type head;
   fxalu_pkg::rsp_type  rsp;
   logic                push;
   logic                pop;
   logic                q_empty;
   logic                q_full;

   fxalu_front u_front (
      .func  (req_func),
      .a_raw (req_a_raw),
      .b_raw (req_b_raw),
      .item  (push_item)
   );

   // A beat is taken whenever the queue has room.
   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   fxalu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // The back is one pipeline shared by every operation: short operations
   // finish in the first stage and ride along, multiply rounds in the second,
   // and the divider fills the rest. It ends in the output register and
   // advances only when that register is free or being read.
   fxalu_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_empty   (q_empty),
      .pop       (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_result_raw     = rsp.res;
   assign rsp_compare_true   = rsp.cmp;
   assign rsp_overflow       = rsp.ovf;
   assign rsp_divide_by_zero = rsp.dbz;

endmodule
